// ----- hdl/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the running sample statistics block.
// ----------------------------------------------------------------------------
package rss_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 24;
   localparam int FRAC_W   = 8;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 54;
   localparam int MEAN_W   = 24;
   localparam int VAR_W    = 39;
   localparam int RMS_W    = 24;
   localparam int CREST_W  = 21;

   // Arithmetic unit widths
   localparam int PROD_W   = 80;
   localparam int MPLIER_W = 40;
   localparam int DIV_W    = 86;
   localparam int DEN_W    = 54;
   localparam int ROOT_W   = 24;
   localparam int RAD_W    = 48;
   localparam int SQREM_W  = 26;
   localparam int DIVCNT_W = 7;
   localparam int SQCNT_W  = 5;

   localparam logic [COUNT_W-1:0] COUNT_FULL = '1;
   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic                       accepted;
      logic [COUNT_W-1:0]         sample_count;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [MEAN_W-1:0]   mean_value;
      logic [VAR_W-1:0]           variance_value;
      logic [RMS_W-1:0]           rms_value;
      logic [CREST_W-1:0]         crest_value;
   } rsp_type;

   // Accumulator snapshot handed from front to back
   typedef struct packed {
      logic                       accepted;
      logic [COUNT_W-1:0]         count;
      logic signed [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]            sq;
      logic signed [SAMPLE_W-1:0] min;
      logic signed [SAMPLE_W-1:0] max;
   } snap_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_START,
      BK_MEAN,
      BK_VMUL_A,
      BK_VMUL_B,
      BK_VMUL_C,
      BK_VDIV,
      BK_RDIV,
      BK_RSQRT,
      BK_CMUL_A,
      BK_CMUL_B,
      BK_CDIV,
      BK_CSQRT,
      BK_DONE
   } back_state_type;

endpackage

// ----- hdl/running_sample_statistics.sv -----
// The back end works each word through the serial multiplier (one multiplier
// bit a cycle), the shared 86-step divider and the 24-step square root; words
// with an empty state skip them.
// Throughput: one word per back-end pass; the front takes words at once while
// the two-entry snapshot queue has room. Reset clears the accumulators, queue
// and result valid flag; the block accepts words in the cycle after reset.
// ----------------------------------------------------------------------------
// running_sample_statistics
// Running count, min, max, mean, variance, rms and crest factor of samples.
// ----------------------------------------------------------------------------
module running_sample_statistics import rss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     wr_en, q_full, q_empty, q_pop;
   snap_type wr_data, rd_data;

   assign req_full = q_full;

   // Accumulate samples
   rss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .req_data   (req_data),
      .queue_full (q_full),
      .wr_en      (wr_en),
      .wr_data    (wr_data)
   );

   // Decouple front and back
   rss_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (rd_data),
      .empty   (q_empty)
   );

   // Derive statistics
   rss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (rd_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/rss_front.sv -----
// ----------------------------------------------------------------------------
// rss_front
// Accepts words; a clear word zeroes the accumulators, a sample word updates
// count, min, max, sum and sum of squares; a snapshot is forwarded per word.
// ----------------------------------------------------------------------------
module rss_front import rss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     wr_en,
   output snap_type wr_data
);

   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in;
   logic                       counted;
   logic signed [SAMPLE_W-1:0] v;
   logic signed [2*SAMPLE_W-1:0] v_sq;

   assign wr_en = push && !queue_full;
   assign v     = req_data.sample;
   assign v_sq  = v * v;

   // Update accumulators
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      counted  = 1'b0;
      if (wr_en) begin
         if (req_data.mode == MODE_CLEAR) begin
            count_in = '0;
            sum_in   = '0;
            sq_in    = '0;
            min_in   = '0;
            max_in   = '0;
         end else if (count_ff != COUNT_FULL) begin
            counted  = 1'b1;
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SUM_W'(v);
            sq_in    = sq_ff + {{(SQ_W-2*SAMPLE_W){1'b0}}, v_sq};
            if (count_ff == '0 || v < min_ff) min_in = v;
            if (count_ff == '0 || v > max_ff) max_in = v;
         end
      end
   end

   // Snapshot of the new state
   always_comb begin
      wr_data.accepted = counted;
      wr_data.count    = count_in;
      wr_data.sum      = sum_in;
      wr_data.sq       = sq_in;
      wr_data.min      = min_in;
      wr_data.max      = max_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

endmodule

// ----- hdl/rss_queue.sv -----
// ----------------------------------------------------------------------------
// rss_queue
// Two-entry queue of accumulator snapshots between front and back.
// ----------------------------------------------------------------------------
module rss_queue import rss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  snap_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output snap_type rd_data,
   output logic     empty
);

   snap_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Store word
   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_wr) wr_ptr_ff <= !wr_ptr_ff;
         if (do_rd) rd_ptr_ff <= !rd_ptr_ff;
         if (do_wr && !do_rd)      count_ff <= count_ff + 2'd1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ----- hdl/rss_back.sv -----
// ----------------------------------------------------------------------------
// rss_back
// Derives mean, variance, rms and crest factor from a snapshot with a
// serial multiplier, a restoring divider and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module rss_back import rss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  snap_type q_data,
   output logic     q_pop,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data
);

   back_state_type state_ff, state_in;
   snap_type       snap_ff, snap_in;

   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [VAR_W-1:0]   var_ff, var_in;
   logic [RMS_W-1:0]   rms_ff, rms_in;
   logic [CREST_W-1:0] crest_ff, crest_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // Serial multiplier
   logic [PROD_W-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic                mul_busy;

   // Restoring divider
   logic [DIV_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    rem_ff, rem_in, den_ff, den_in;
   logic [DIVCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DEN_W:0]      rem_sh, rem_diff;
   logic                div_ge, div_busy;

   // Square root
   logic [RAD_W-1:0]   src_ff, src_in;
   logic [SQREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SQCNT_W-1:0] scnt_ff, scnt_in;
   logic [SQREM_W+1:0] srem_sh, strial, sdiff;
   logic               sq_ge, sq_busy;

   // Output register
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in, out_load, out_free;

   logic [SUM_W-1:0]      sum_bits, sum_abs;
   logic [SAMPLE_W:0]     min_abs, max_abs, peak;
   logic [MEAN_W-1:0]     quot_mean;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_pop;

   // Operand preparation
   always_comb begin
      sum_bits  = snap_ff.sum;
      sum_abs   = sum_bits[SUM_W-1] ? (~sum_bits + 1'b1) : sum_bits;
      min_abs   = snap_ff.min[SAMPLE_W-1] ? ({1'b0, ~snap_ff.min} + 1'b1)
                                          : {1'b0, snap_ff.min};
      max_abs   = snap_ff.max[SAMPLE_W-1] ? ({1'b0, ~snap_ff.max} + 1'b1)
                                          : {1'b0, snap_ff.max};
      peak      = (min_abs > max_abs) ? min_abs : max_abs;
      quot_mean = num_ff[MEAN_W-1:0];
   end

   // Step the arithmetic units
   always_comb begin
      mul_busy = (mplier_ff != '0);
      div_busy = (dcnt_ff != '0);
      sq_busy  = (scnt_ff != '0);
      rem_sh   = {rem_ff, num_ff[DIV_W-1]};
      div_ge   = (rem_sh >= {1'b0, den_ff});
      rem_diff = rem_sh - {1'b0, den_ff};
      srem_sh  = {srem_ff, src_ff[RAD_W-1:RAD_W-2]};
      strial   = {2'b00, root_ff, 2'b01};
      sq_ge    = (srem_sh >= strial);
      sdiff    = srem_sh - strial;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      snap_in      = snap_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rms_in       = rms_ff;
      crest_in     = crest_ff;
      prod_in      = prod_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;

      acc_in    = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
      mcand_in  = mcand_ff << 1;
      mplier_in = mplier_ff >> 1;

      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dcnt_in = dcnt_ff;
      if (div_busy) begin
         num_in  = {num_ff[DIV_W-2:0], div_ge};
         rem_in  = div_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         dcnt_in = dcnt_ff - 1'b1;
      end

      src_in  = src_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      scnt_in = scnt_ff;
      if (sq_busy) begin
         src_in  = {src_ff[RAD_W-3:0], 2'b00};
         srem_in = sq_ge ? sdiff[SQREM_W-1:0] : srem_sh[SQREM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], sq_ge};
         scnt_in = scnt_ff - 1'b1;
      end

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               snap_in  = q_data;
               mean_in  = '0;
               var_in   = '0;
               rms_in   = '0;
               crest_in = '0;
               state_in = BK_START;
            end
         end
         BK_START: begin
            if (snap_ff.count == '0) begin
               state_in = BK_DONE;
            end else begin
               num_in   = {{(DIV_W-SUM_W-FRAC_W){1'b0}}, sum_abs, {FRAC_W{1'b0}}};
               den_in   = {{(DEN_W-COUNT_W){1'b0}}, snap_ff.count};
               rem_in   = '0;
               dcnt_in  = DIVCNT_W'(DIV_W);
               state_in = BK_MEAN;
            end
         end
         BK_MEAN: begin
            if (!div_busy) begin
               mean_in = sum_bits[SUM_W-1] ? (~quot_mean + 1'b1) : quot_mean;
               if (snap_ff.count >= COUNT_W'(2)) begin
                  acc_in    = '0;
                  mcand_in  = {{(PROD_W-SQ_W){1'b0}}, snap_ff.sq};
                  mplier_in = {{(MPLIER_W-COUNT_W){1'b0}}, snap_ff.count};
                  state_in  = BK_VMUL_A;
               end else begin
                  num_in   = {{(DIV_W-SQ_W-2*FRAC_W){1'b0}}, snap_ff.sq,
                              {(2*FRAC_W){1'b0}}};
                  den_in   = {{(DEN_W-COUNT_W){1'b0}}, snap_ff.count};
                  rem_in   = '0;
                  dcnt_in  = DIVCNT_W'(DIV_W);
                  state_in = BK_RDIV;
               end
            end
         end
         BK_VMUL_A: begin
            if (!mul_busy) begin
               prod_in   = acc_ff;
               acc_in    = '0;
               mcand_in  = {{(PROD_W-SUM_W){1'b0}}, sum_abs};
               mplier_in = sum_abs;
               state_in  = BK_VMUL_B;
            end
         end
         BK_VMUL_B: begin
            if (!mul_busy) begin
               prod_in   = prod_ff - acc_ff;
               acc_in    = '0;
               mcand_in  = {{(PROD_W-COUNT_W){1'b0}}, snap_ff.count};
               mplier_in = {{(MPLIER_W-COUNT_W){1'b0}}, snap_ff.count};
               state_in  = BK_VMUL_C;
            end
         end
         BK_VMUL_C: begin
            if (!mul_busy) begin
               num_in   = {prod_ff[DIV_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
               den_in   = acc_ff[DEN_W-1:0];
               rem_in   = '0;
               dcnt_in  = DIVCNT_W'(DIV_W);
               state_in = BK_VDIV;
            end
         end
         BK_VDIV: begin
            if (!div_busy) begin
               var_in   = num_ff[VAR_W-1:0];
               num_in   = {{(DIV_W-SQ_W-2*FRAC_W){1'b0}}, snap_ff.sq,
                           {(2*FRAC_W){1'b0}}};
               den_in   = {{(DEN_W-COUNT_W){1'b0}}, snap_ff.count};
               rem_in   = '0;
               dcnt_in  = DIVCNT_W'(DIV_W);
               state_in = BK_RDIV;
            end
         end
         BK_RDIV: begin
            if (!div_busy) begin
               src_in   = num_ff[RAD_W-1:0];
               srem_in  = '0;
               root_in  = '0;
               scnt_in  = SQCNT_W'(ROOT_W);
               state_in = BK_RSQRT;
            end
         end
         BK_RSQRT: begin
            if (!sq_busy) begin
               rms_in = root_ff;
               if (snap_ff.sq != '0) begin
                  acc_in    = '0;
                  mcand_in  = {{(PROD_W-SAMPLE_W-1){1'b0}}, peak};
                  mplier_in = {{(MPLIER_W-SAMPLE_W-1){1'b0}}, peak};
                  state_in  = BK_CMUL_A;
               end else begin
                  state_in = BK_DONE;
               end
            end
         end
         BK_CMUL_A: begin
            if (!mul_busy) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = {{(MPLIER_W-COUNT_W){1'b0}}, snap_ff.count};
               state_in  = BK_CMUL_B;
            end
         end
         BK_CMUL_B: begin
            if (!mul_busy) begin
               num_in   = {acc_ff[DIV_W-2*FRAC_W-1:0], {(2*FRAC_W){1'b0}}};
               den_in   = snap_ff.sq;
               rem_in   = '0;
               dcnt_in  = DIVCNT_W'(DIV_W);
               state_in = BK_CDIV;
            end
         end
         BK_CDIV: begin
            if (!div_busy) begin
               src_in   = num_ff[RAD_W-1:0];
               srem_in  = '0;
               root_in  = '0;
               scnt_in  = SQCNT_W'(ROOT_W);
               state_in = BK_CSQRT;
            end
         end
         BK_CSQRT: begin
            if (!sq_busy) begin
               crest_in = root_ff[CREST_W-1:0];
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Build result word
   always_comb begin
      out_in.accepted       = snap_ff.accepted;
      out_in.sample_count   = snap_ff.count;
      out_in.min_value      = snap_ff.min;
      out_in.max_value      = snap_ff.max;
      out_in.mean_value     = mean_ff;
      out_in.variance_value = var_ff;
      out_in.rms_value      = rms_ff;
      out_in.crest_value    = crest_ff;
      if (out_load)         out_valid_in = 1'b1;
      else if (rsp_pop)     out_valid_in = 1'b0;
      else                  out_valid_in = out_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
         scnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         dcnt_ff      <= dcnt_in;
         scnt_ff      <= scnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      snap_ff   <= snap_in;
      mean_ff   <= mean_in;
      var_ff    <= var_in;
      rms_ff    <= rms_in;
      crest_ff  <= crest_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      src_ff    <= src_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      if (out_load) out_ff <= out_in;
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_sample_statistics. A queue of sample and
// clear words is pushed in random bursts. Each accepted word updates a local
// model of the statistics, and every popped result is compared field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
   import rss_pkg::*;

   localparam int  RANDOM_WORDS = 1600;
   localparam int  DRAIN_CYCLES = 1200;
   localparam int  CYCLE_LIMIT  = 6000000;
   localparam int  PAUSE_AT     = 700;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   req_type stim_q[$];
   rsp_type expected_q[$];
   int      words_taken = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   bit      stim_ready = 1'b0;

   // statistics model
   longint      model_sum = 0;
   logic [63:0] model_sq = '0;
   longint      model_min = 0;
   longint      model_max = 0;
   logic [63:0] model_count = '0;

   running_sample_statistics dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
      logic [127:0] quo;
      quo = num / den;
      return (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Update the model with one word and compute the statistics it reports
   task automatic predict_stats(input req_type w, output rsp_type r);
      longint       v;
      logic [63:0]  smag, q, peak, amin, amax;
      logic [127:0] diff;
      r = '0;
      if (w.mode == MODE_CLEAR) begin
         model_sum = 0; model_sq = '0; model_min = 0; model_max = 0;
         model_count = '0;
      end else if (model_count < {40'd0, COUNT_FULL}) begin
         v = longint'(w.sample);
         if (model_count == 0) begin
            model_min = v; model_max = v;
         end else begin
            if (v < model_min) model_min = v;
            if (v > model_max) model_max = v;
         end
         model_sum = model_sum + v;
         model_sq = model_sq + 64'(v * v);
         model_count = model_count + 1;
         r.accepted = 1'b1;
      end
      r.sample_count = model_count[COUNT_W-1:0];
      if (model_count != 0) begin
         smag = (model_sum < 0) ? 64'(-model_sum) : 64'(model_sum);
         q = (smag << FRAC_W) / model_count;
         if (model_sum < 0) q = -q;
         r.min_value = model_min[SAMPLE_W-1:0];
         r.max_value = model_max[SAMPLE_W-1:0];
         r.mean_value = q[MEAN_W-1:0];
         if (model_count >= 2) begin
            diff = 128'(model_count) * 128'(model_sq) - 128'(smag) * 128'(smag);
            q = div_sat(diff << FRAC_W, model_count * model_count);
            r.variance_value = q[VAR_W-1:0];
         end
         q = int_sqrt(div_sat(128'(model_sq) << (2 * FRAC_W), model_count));
         r.rms_value = q[RMS_W-1:0];
         if (model_sq != 0) begin
            amin = (model_min < 0) ? 64'(-model_min) : 64'(model_min);
            amax = (model_max < 0) ? 64'(-model_max) : 64'(model_max);
            peak = (amin > amax) ? amin : amax;
            q = int_sqrt(div_sat((128'(peak * peak) * 128'(model_count))
                                 << (2 * FRAC_W), model_sq));
            r.crest_value = q[CREST_W-1:0];
         end
      end
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", field, got, want);
      error_count++;
   endtask

   function automatic req_type make_word(bit mode, logic [15:0] value);
      req_type w;
      w.mode = mode;
      w.sample = value;
      return w;
   endfunction

   // Fill the stimulus queue: directed corners first, then random
   initial begin
      int kind;
      logic [15:0] val;
      stim_q.push_back(make_word(MODE_CLEAR, 16'h0000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h0000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h0000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h0001));
      stim_q.push_back(make_word(MODE_CLEAR, 16'hFFFF));
      stim_q.push_back(make_word(MODE_PUSH, 16'h8000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h7FFF));
      stim_q.push_back(make_word(MODE_PUSH, 16'h8000));
      stim_q.push_back(make_word(MODE_PUSH, 16'hFFFF));
      stim_q.push_back(make_word(MODE_CLEAR, 16'h5A5A));
      stim_q.push_back(make_word(MODE_PUSH, 16'hFFFF));
      stim_q.push_back(make_word(MODE_PUSH, 16'h0001));
      stim_q.push_back(make_word(MODE_PUSH, 16'h7FFF));
      stim_q.push_back(make_word(MODE_PUSH, 16'h7FFF));
      stim_q.push_back(make_word(MODE_CLEAR, 16'hA5A5));
      stim_q.push_back(make_word(MODE_PUSH, 16'h8000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h8000));
      stim_q.push_back(make_word(MODE_PUSH, 16'h0000));
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         kind = $urandom_range(0, 99);
         case (kind % 4)
            0: val = $urandom_range(0, 65535);
            1: val = 16'($signed($urandom_range(0, 16)) - 8);
            2: val = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: val = 16'($urandom_range(0, 2047));
         endcase
         stim_q.push_back(make_word((kind < 3) ? MODE_CLEAR : MODE_PUSH, val));
      end
      stim_ready = 1'b1;
   end

   // Hold reset from time zero, then release it
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Drive request words in bursts with gaps; pause once for a full drain
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && stim_ready && words_taken < stim_q.size()) begin
         if (words_taken == PAUSE_AT && expected_q.size() != 0) begin
            req_push <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else begin
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600);
            end else begin
               burst_left <= burst_left - 1;
            end
            req_push <= 1'b1;
            req_data <= stim_q[words_taken];
         end
      end else begin
         req_push <= 1'b0;
      end
   end

   // Stall the result side on its own pattern
   int pop_phase = 0;
   always @(negedge clock) begin
      pop_phase <= (pop_phase + 1) % 4096;
      if (pop_phase < 1024) rsp_pop <= 1'b1;
      else if (pop_phase < 2048) rsp_pop <= ($urandom_range(0, 7) == 0);
      else rsp_pop <= ($urandom_range(0, 1) != 0);
   end

   // Capture accepted requests and check popped results
   always @(posedge clock) begin
      rsp_type predicted, want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_push && !req_full) begin
         predict_stats(req_data, predicted);
         expected_q.push_back(predicted);
         words_taken <= words_taken + 1;
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            $display("unexpected result word: %0h", rsp_data);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.accepted != want.accepted)
               report_mismatch("accepted", rsp_data.accepted, want.accepted);
            if (rsp_data.sample_count != want.sample_count)
               report_mismatch("sample_count", rsp_data.sample_count, want.sample_count);
            if (rsp_data.min_value != want.min_value)
               report_mismatch("min_value", rsp_data.min_value, want.min_value);
            if (rsp_data.max_value != want.max_value)
               report_mismatch("max_value", rsp_data.max_value, want.max_value);
            if (rsp_data.mean_value != want.mean_value)
               report_mismatch("mean_value", rsp_data.mean_value, want.mean_value);
            if (rsp_data.variance_value != want.variance_value)
               report_mismatch("variance_value", rsp_data.variance_value,
                               want.variance_value);
            if (rsp_data.rms_value != want.rms_value)
               report_mismatch("rms_value", rsp_data.rms_value, want.rms_value);
            if (rsp_data.crest_value != want.crest_value)
               report_mismatch("crest_value", rsp_data.crest_value, want.crest_value);
         end
      end
   end

   // Stop on timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Wait for all words and results, drain, then report
   initial begin
      wait (stim_ready);
      wait (!reset && words_taken == stim_q.size() && expected_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
